>>> hw/rtl/tdpt_pkg.sv
`timescale 1ns / 1ps

package tdpt_pkg;

  // Width at which both operands are taken; bit VALUE_BITS-1 is the sign.
  localparam int unsigned VALUE_BITS = 32;

  // Bit counter for one restoring-division pass (counts VALUE_BITS-1 down to 0).
  localparam int unsigned CNT_W = $clog2(VALUE_BITS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_CHECK,
    ST_DONE
  } state_e;

endpackage

>>> hw/rtl/trial_division_prime_test_top.sv
`timescale 1ns / 1ps

// Trial-division prime test. Each transaction carries a signed test value and
// a compare value and yields one result with four flags: prime, even, odd and
// equal. Parity and equality are settled when the transaction is taken; zero,
// one, two, negative values and other even values skip the divisor search
// and go straight to the result. Odd values of three and up run the
// divisor search: odd divisors d = 3, 5, 7, ... are tried through one shared
// restoring divider that produces one quotient bit per cycle. The search
// ends at the first exact divisor (not prime) or as soon as d exceeds n / d
// (prime). Worst case is a large prime: about sqrt(n) / 2 trials, near 23,200
// trials for n close to 2^31. One transaction is worked on at a time;
// in_stall_o stays high until the result is written to the output register.
// The next transaction may be taken while a finished result still waits on
// out_stall_i.
module trial_division_prime_test_top (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] test_value_i,
  input  logic [31:0] compare_value_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        is_prime_o,
  output logic        is_even_o,
  output logic        is_odd_o,
  output logic        is_equal_o
);

  localparam int unsigned VB    = tdpt_pkg::VALUE_BITS;
  localparam int unsigned CNT_W = tdpt_pkg::CNT_W;

  tdpt_pkg::state_e state_q, state_d;

  // working registers of the divisor search
  logic [VB-1:0]    n_q, n_d;      // value under test
  logic [VB-1:0]    dv_q, dv_d;    // current trial divisor
  logic [VB-1:0]    rem_q, rem_d;  // partial remainder
  logic [VB-1:0]    quo_q, quo_d;  // dividend bits out, quotient bits in
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             prime_q, prime_d;
  logic             eq_q, eq_d;
  logic             odd_q, odd_d;

  // output register
  logic out_valid_q, out_valid_d;
  logic o_prime_q, o_prime_d;
  logic o_odd_q, o_odd_d;
  logic o_eq_q, o_eq_d;

  logic          in_take;
  logic          out_free;
  logic [VB-1:0] tv;
  logic [VB-1:0] cv;
  logic          early;     // settled without a divisor search
  logic          early_prime;
  logic [VB:0]   rem_shift;
  logic [VB:0]   rem_sub;
  logic          fits;
  logic          div_last;
  logic          past_root; // d > n/d: no divisor left to try
  logic          exact;

  assign tv = test_value_i[VB-1:0];
  assign cv = compare_value_i[VB-1:0];

  assign in_take  = in_valid_i && (state_q == tdpt_pkg::ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  // negative, below two, or even: answer known up front
  always_comb begin
    early       = 1'b0;
    early_prime = 1'b0;
    if (tv[VB-1]) begin
      early = 1'b1;
    end else if (tv < VB'(2)) begin
      early = 1'b1;
    end else if (tv == VB'(2)) begin
      early       = 1'b1;
      early_prime = 1'b1;
    end else if (!tv[0]) begin
      early = 1'b1;
    end
  end

  // shared restoring-division step
  assign rem_shift = {rem_q, quo_q[VB-1]};
  assign rem_sub   = rem_shift - {1'b0, dv_q};
  assign fits      = !rem_sub[VB];
  assign div_last  = (cnt_q == '0);
  assign past_root = (dv_q > quo_q);
  assign exact     = (rem_q == '0);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tdpt_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = early ? tdpt_pkg::ST_DONE : tdpt_pkg::ST_DIV;
        end
      end
      tdpt_pkg::ST_DIV: begin
        if (div_last) begin
          state_d = tdpt_pkg::ST_CHECK;
        end
      end
      tdpt_pkg::ST_CHECK: begin
        if (past_root || exact) begin
          state_d = tdpt_pkg::ST_DONE;
        end else begin
          state_d = tdpt_pkg::ST_DIV;
        end
      end
      tdpt_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = tdpt_pkg::ST_IDLE;
        end
      end
      default: state_d = tdpt_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    n_d         = n_q;
    dv_d        = dv_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    cnt_d       = cnt_q;
    prime_d     = prime_q;
    eq_d        = eq_q;
    odd_d       = odd_q;
    out_valid_d = out_valid_q && out_stall_i;
    o_prime_d   = o_prime_q;
    o_odd_d     = o_odd_q;
    o_eq_d      = o_eq_q;

    unique case (state_q)
      tdpt_pkg::ST_IDLE: begin
        if (in_take) begin
          n_d     = tv;
          eq_d    = (tv == cv);
          odd_d   = tv[0];
          prime_d = early_prime;
          dv_d    = VB'(3);
          rem_d   = '0;
          quo_d   = tv;
          cnt_d   = CNT_W'(VB - 1);
        end
      end
      tdpt_pkg::ST_DIV: begin
        rem_d = fits ? rem_sub[VB-1:0] : rem_shift[VB-1:0];
        quo_d = {quo_q[VB-2:0], fits};
        cnt_d = cnt_q - CNT_W'(1);
      end
      tdpt_pkg::ST_CHECK: begin
        if (past_root) begin
          prime_d = 1'b1;
        end else if (exact) begin
          prime_d = 1'b0;
        end else begin
          dv_d  = dv_q + VB'(2);
          rem_d = '0;
          quo_d = n_q;
          cnt_d = CNT_W'(VB - 1);
        end
      end
      tdpt_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          o_prime_d   = prime_q;
          o_odd_d     = odd_q;
          o_eq_d      = eq_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tdpt_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q       <= n_d;
    dv_q      <= dv_d;
    rem_q     <= rem_d;
    quo_q     <= quo_d;
    cnt_q     <= cnt_d;
    prime_q   <= prime_d;
    eq_q      <= eq_d;
    odd_q     <= odd_d;
    o_prime_q <= o_prime_d;
    o_odd_q   <= o_odd_d;
    o_eq_q    <= o_eq_d;
  end

  assign in_stall_o  = (state_q != tdpt_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign is_prime_o  = o_prime_q;
  assign is_odd_o    = o_odd_q;
  assign is_even_o   = !o_odd_q;
  assign is_equal_o  = o_eq_q;

endmodule
